>>> rtl/tss_pkg.sv
// Shared types and constants for the task scheduler selector.
`default_nettype none
package tss_pkg;
  localparam int MaxTasksDef = 16;
  localparam int SlotW = 4;
  localparam int SlotCount = 16;
  localparam logic [15:0] LfsrSeed = 16'hACE1;
  localparam logic [15:0] LfsrMask = 16'hB400;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0, KIND_REMOVE = 2'd1, KIND_SET_LEFT = 2'd2, KIND_CHOOSE = 2'd3
  } kind_t;
  typedef enum logic [1:0] {
    POL_FIFO = 2'd0, POL_SRTF = 2'd1, POL_PRIO = 2'd2, POL_AGING = 2'd3
  } policy_t;
  localparam logic [1:0] CauseQuantum = 2'd0;
  localparam logic [1:0] CauseNewTask = 2'd1;
  localparam logic [1:0] StatReady = 2'd0;
  localparam logic [1:0] StatTerm = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REMOVE, ST_AGE, ST_SCAN, ST_DONE
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request and do insert and set-left updates
    logic rm_step;   // one compaction step
    logic age_step;  // age one listed entry
    logic scan_init; // set initial candidate
    logic scan_step; // compare one listed entry
    logic finish;    // write back winner, emit result
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last;        // index past the last listed entry
    logic empty;       // list empty
    logic need_age;    // aging pass required
    logic direct;      // answer known without scan
  } stat_t;
endpackage
`default_nettype wire

>>> rtl/tss_ctrl.sv
// Controller state machine for the task scheduler selector.
`default_nettype none
module tss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     kind,
  input  wire tss_pkg::stat_t st,
  output logic                busy,
  output tss_pkg::cmd_t       cmd
);
  tss_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= tss_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != tss_pkg::ST_IDLE);
    unique case (state)
      tss_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (kind == tss_pkg::KIND_REMOVE) state_next = tss_pkg::ST_REMOVE;
          else if (kind == tss_pkg::KIND_CHOOSE) state_next = tss_pkg::ST_AGE;
        end
      end
      tss_pkg::ST_REMOVE: begin
        if (st.last) state_next = tss_pkg::ST_IDLE;
        else cmd.rm_step = 1'b1;
      end
      tss_pkg::ST_AGE: begin
        if (st.direct) begin
          cmd.finish = 1'b1;
          state_next = tss_pkg::ST_IDLE;
        end else if (st.need_age && !st.last) begin
          cmd.age_step = 1'b1;
        end else begin
          cmd.scan_init = 1'b1;
          state_next = tss_pkg::ST_SCAN;
        end
      end
      tss_pkg::ST_SCAN: begin
        if (st.last) state_next = tss_pkg::ST_DONE;
        else cmd.scan_step = 1'b1;
      end
      tss_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = tss_pkg::ST_IDLE;
      end
      default: state_next = tss_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/tss_dpath.sv
// Datapath for the task scheduler selector: task table, ready list, scan unit.
`default_nettype none
module tss_dpath #(
  parameter int MaxTasks = tss_pkg::MaxTasksDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire tss_pkg::cmd_t           cmd,
  output tss_pkg::stat_t               st,
  input  wire logic [1:0]              policy,
  input  wire logic [7:0]              aging_step,
  input  wire logic [1:0]              kind,
  input  wire logic [3:0]              slot,
  input  wire logic [15:0]             start_time,
  input  wire logic [15:0]             run_length,
  input  wire logic [15:0]             time_left,
  input  wire logic [7:0]              base_priority,
  input  wire logic                    current_present,
  input  wire logic [3:0]              current_slot,
  input  wire logic [1:0]              current_status,
  input  wire logic [1:0]              preempt_cause,
  output logic                         chosen_valid,
  output logic                         chosen_present,
  output logic [3:0]                   chosen_slot,
  output logic                         random_used
);
  localparam int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW = $clog2(MaxTasks + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxTasks);

  // ready list: each position read at its own index through a mux
  logic [3:0]      ready_order [MaxTasks];
  logic [CntW-1:0] ready_count;
  logic [15:0]     arrival_store [tss_pkg::SlotCount];
  logic [15:0]     length_store  [tss_pkg::SlotCount];
  logic [15:0]     left_store    [tss_pkg::SlotCount];
  logic [7:0]      static_prio_store  [tss_pkg::SlotCount];
  logic [15:0]     dynamic_prio_store [tss_pkg::SlotCount];
  logic [15:0]     tie_lfsr;

  // captured request
  logic [3:0]      r_slot, r_cur;
  logic            r_cur_ok;
  logic [1:0]      r_status, r_cause, r_pol;
  logic [CntW-1:0] idx, wr;
  logic [3:0]      ch;
  logic            rnd;

  logic [3:0]  t;
  logic [IdxW-1:0] idx_i;
  assign idx_i = idx[IdxW-1:0];
  assign t = ready_order[idx_i];

  // aging pass finished: need_age drops so the scan can begin
  logic aged_done;

  // status to controller
  always_comb begin
    st.last = (idx >= ready_count);
    st.empty = (ready_count == '0);
    st.need_age = (r_pol == tss_pkg::POL_AGING) && !aged_done &&
                  (r_cause == tss_pkg::CauseNewTask ||
                   (r_cur_ok && r_status == tss_pkg::StatTerm));
    st.direct = 1'b0;
    if (r_pol == tss_pkg::POL_FIFO) begin
      st.direct = 1'b1;
    end else if (ready_count == '0) begin
      st.direct = 1'b1;
    end else if (r_pol == tss_pkg::POL_AGING && r_cause == tss_pkg::CauseQuantum) begin
      st.direct = 1'b1;
    end
  end

  // comparison of scanned entry t against candidate ch
  logic [15:0] kt, kc;
  logic better, equal, prio_tie, prio_pick_t;
  logic [7:0] st_t, st_c;
  always_comb begin
    st_t = static_prio_store[t];
    st_c = static_prio_store[ch];
    unique case (r_pol)
      tss_pkg::POL_SRTF: begin kt = left_store[t]; kc = left_store[ch]; end
      tss_pkg::POL_PRIO: begin kt = {8'd0, st_t}; kc = {8'd0, st_c}; end
      default:           begin kt = dynamic_prio_store[t]; kc = dynamic_prio_store[ch]; end
    endcase
    better = (r_pol == tss_pkg::POL_SRTF) ? (kt < kc) : (kt > kc);
    equal = (kt == kc);
    prio_tie = (r_pol == tss_pkg::POL_AGING) && (st_c != st_t);
    prio_pick_t = (st_t > st_c);
  end

  // base tie break; lfsr consulted only when all keys match
  logic [3:0] tie_pick;
  logic       tie_rand;
  always_comb begin
    tie_rand = 1'b0;
    tie_pick = ch;
    if (ch == t) tie_pick = ch;
    else if (r_cur_ok && ch == r_cur) tie_pick = ch;
    else if (r_cur_ok && t == r_cur) tie_pick = t;
    else if (arrival_store[ch] < arrival_store[t]) tie_pick = ch;
    else if (arrival_store[t] < arrival_store[ch]) tie_pick = t;
    else if (length_store[ch] < length_store[t]) tie_pick = ch;
    else if (length_store[t] < length_store[ch]) tie_pick = t;
    else begin
      tie_rand = 1'b1;
      tie_pick = tie_lfsr[0] ? ch : t;
    end
  end

  logic [16:0] aged;
  assign aged = {1'b0, dynamic_prio_store[t]} + {9'd0, aging_step};

  // control registers
  always_ff @(posedge clk) begin
    chosen_valid <= 1'b0;
    if (rst) begin
      ready_count <= '0;
      tie_lfsr <= tss_pkg::LfsrSeed;
      idx <= '0;
      wr <= '0;
    end else begin
      if (cmd.load) begin
        idx <= '0;
        wr <= '0;
        if (kind == tss_pkg::KIND_INSERT && ready_count < MaxCnt) begin
          ready_count <= ready_count + 1'b1;
        end
      end
      if (cmd.rm_step) begin
        idx <= idx + 1'b1;
        if (t != r_slot) wr <= wr + 1'b1;
        if (idx + 1'b1 >= ready_count)
          ready_count <= (t != r_slot) ? wr + 1'b1 : wr;
      end
      if (cmd.age_step) begin
        idx <= (idx + 1'b1 >= ready_count) ? '0 : idx + 1'b1;
      end
      if (cmd.scan_init) idx <= '0;
      if (cmd.scan_step) begin
        idx <= idx + 1'b1;
        if (!better && equal && !prio_tie && tie_rand)
          tie_lfsr <= tie_lfsr[0] ? ((tie_lfsr >> 1) ^ tss_pkg::LfsrMask)
                                  : (tie_lfsr >> 1);
      end
      if (cmd.finish) chosen_valid <= 1'b1;
    end
  end

  // set once the last listed entry has been aged
  always_ff @(posedge clk) begin
    if (rst || cmd.load) aged_done <= 1'b0;
    else if (cmd.age_step && idx + 1'b1 >= ready_count) aged_done <= 1'b1;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_slot <= slot;
      r_cur <= current_slot;
      r_cur_ok <= current_present;
      r_status <= current_status;
      r_cause <= preempt_cause;
      r_pol <= policy;
      rnd <= 1'b0;
      if (kind == tss_pkg::KIND_INSERT) begin
        arrival_store[slot] <= start_time;
        length_store[slot] <= run_length;
        left_store[slot] <= time_left;
        static_prio_store[slot] <= base_priority;
        dynamic_prio_store[slot] <= {8'd0, base_priority};
        if (ready_count < MaxCnt) ready_order[ready_count[IdxW-1:0]] <= slot;
      end
      if (kind == tss_pkg::KIND_SET_LEFT) left_store[slot] <= time_left;
    end
    if (cmd.rm_step && t != r_slot) ready_order[wr[IdxW-1:0]] <= t;
    if (cmd.age_step)
      dynamic_prio_store[t] <= aged[16] ? 16'hFFFF : aged[15:0];
    if (cmd.scan_init)
      ch <= (r_cur_ok && r_status == tss_pkg::StatReady) ? r_cur : ready_order[0];
    if (cmd.scan_step) begin
      if (better) ch <= t;
      else if (equal) begin
        if (prio_tie) ch <= prio_pick_t ? t : ch;
        else begin
          ch <= tie_pick;
          if (tie_rand) rnd <= 1'b1;
        end
      end
    end
    if (cmd.finish) begin
      random_used <= rnd;
      if (r_pol == tss_pkg::POL_FIFO) begin
        chosen_present <= (ready_count != '0) &&
                          (r_cause != tss_pkg::CauseNewTask || r_cur_ok);
        chosen_slot <= (ready_count == '0) ? 4'd0 :
                       (r_cause == tss_pkg::CauseNewTask) ? (r_cur_ok ? r_cur : 4'd0)
                                                          : ready_order[0];
      end else if (ready_count == '0) begin
        chosen_present <= r_cur_ok && r_status != tss_pkg::StatTerm;
        chosen_slot <= (r_cur_ok && r_status != tss_pkg::StatTerm) ? r_cur : 4'd0;
      end else if (r_pol == tss_pkg::POL_AGING && r_cause == tss_pkg::CauseQuantum) begin
        chosen_present <= r_cur_ok;
        chosen_slot <= r_cur_ok ? r_cur : 4'd0;
      end else begin
        chosen_present <= 1'b1;
        chosen_slot <= ch;
        if (r_pol == tss_pkg::POL_AGING)
          dynamic_prio_store[ch] <= {8'd0, static_prio_store[ch]};
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/task_scheduler_selector_core.sv
// Top level of the task scheduler selector.
// Insert and set remaining finish on the load command; remove compacts the list one
// entry per step; choose answers directly where it can, else runs an aging pass, then a
// list scan, one entry per cycle through the shared compare unit.
// One request at a time; result strobe valid lasts one cycle, receiver cannot stall.
// Synchronous reset empties the ready list and seeds the LFSR with 0xACE1.
`default_nettype none
module task_scheduler_selector_core #(
  parameter int MaxTasks = tss_pkg::MaxTasksDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [3:0]  slot,
  input  wire logic [15:0] start_time,
  input  wire logic [15:0] run_length,
  input  wire logic [15:0] time_left,
  input  wire logic [7:0]  base_priority,
  input  wire logic        current_present,
  input  wire logic [3:0]  current_slot,
  input  wire logic [1:0]  current_status,
  input  wire logic [1:0]  preempt_cause,
  output logic             result_strobe,
  output logic             chosen_present,
  output logic [3:0]       chosen_slot,
  output logic             random_used
);
  logic [1:0] policy;
  logic [7:0] aging_step;
  tss_pkg::cmd_t  cmd;
  tss_pkg::stat_t st;
  logic busy_i;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 2'd0;
      aging_step <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) policy <= cfg_data[1:0];
      else aging_step <= cfg_data;
    end
  end

  tss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(kind), .st(st), .busy(busy_i), .cmd(cmd)
  );
  assign busy = busy_i;

  tss_dpath #(.MaxTasks(MaxTasks)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .policy(policy), .aging_step(aging_step),
    .kind(kind), .slot(slot), .start_time(start_time), .run_length(run_length),
    .time_left(time_left), .base_priority(base_priority),
    .current_present(current_present), .current_slot(current_slot),
    .current_status(current_status), .preempt_cause(preempt_cause),
    .chosen_valid(result_strobe), .chosen_present(chosen_present),
    .chosen_slot(chosen_slot), .random_used(random_used)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !(result_strobe && busy)) else $error("strobe while busy");
  a_none_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !chosen_present) |-> (chosen_slot == 4'd0))
    else $error("absent choice with nonzero slot");
  a_rand_needs_pick: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && random_used) |-> chosen_present)
    else $error("random flag without choice");
`endif
endmodule
`default_nettype wire
